// ===== rtl/core/lspe_pkg.sv =====
// Shared types, constants and the sequencer program of the LED strip pattern engine.
// Depends on nothing; used by lspe_pixel and led_strip_pattern_engine.
package lspe_pkg;

  localparam int LED_COUNT_DEF    = 19;
  localparam int MIDDLE_INDEX_DEF = 9;
  localparam int SHADOW_COUNT     = 3;
  localparam int OFFSET_W         = 5;
  localparam logic [OFFSET_W-1:0] OFFSET_MAX = 5'd31;

  localparam logic [1:0] ACT_COMMAND = 2'd0;
  localparam logic [1:0] ACT_FADE    = 2'd1;
  localparam logic [1:0] ACT_RUN     = 2'd2;
  localparam logic [1:0] ACT_RENDER  = 2'd3;

  localparam logic [7:0] MODE_FADE = 8'd1;
  localparam logic [7:0] MODE_RUN  = 8'd2;

  localparam logic [1:0] KIND_SOLID = 2'd0;
  localparam logic [1:0] KIND_FADE  = 2'd1;
  localparam logic [1:0] KIND_RUN   = 2'd2;
  localparam logic [1:0] KIND_BLACK = 2'd3;

  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] STEP_FETCH  = 3'd0;
  localparam logic [STEP_W-1:0] STEP_CMD    = 3'd1;
  localparam logic [STEP_W-1:0] STEP_FADE   = 3'd2;
  localparam logic [STEP_W-1:0] STEP_RUN    = 3'd3;
  localparam logic [STEP_W-1:0] STEP_SETUP  = 3'd4;
  localparam logic [STEP_W-1:0] STEP_PIXEL  = 3'd5;
  localparam logic [STEP_W-1:0] STEP_COMMIT = 3'd6;

  localparam logic [2:0] OP_FETCH  = 3'd0;
  localparam logic [2:0] OP_CMD    = 3'd1;
  localparam logic [2:0] OP_FADE   = 3'd2;
  localparam logic [2:0] OP_RUN    = 3'd3;
  localparam logic [2:0] OP_SETUP  = 3'd4;
  localparam logic [2:0] OP_PIXEL  = 3'd5;
  localparam logic [2:0] OP_COMMIT = 3'd6;

  localparam logic [1:0] COND_ALWAYS   = 2'd0;
  localparam logic [1:0] COND_DISPATCH = 2'd1;
  localparam logic [1:0] COND_EMPTY    = 2'd2;
  localparam logic [1:0] COND_LAST     = 2'd3;

  typedef struct packed {
    logic [2:0]        op;
    logic [1:0]        cond;
    logic [STEP_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] brightness;
    logic [7:0] mode;
  } in_item_t;

  typedef struct packed {
    logic [4:0] pixel_index;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] frame_brightness;
    logic       last_pixel;
  } out_item_t;

  function automatic ctrl_t program_word(input logic [STEP_W-1:0] step);
    ctrl_t w;
    case (step)
      STEP_FETCH:  w = '{op: OP_FETCH,  cond: COND_DISPATCH, target: STEP_CMD};
      STEP_CMD:    w = '{op: OP_CMD,    cond: COND_ALWAYS,   target: STEP_FETCH};
      STEP_FADE:   w = '{op: OP_FADE,   cond: COND_ALWAYS,   target: STEP_FETCH};
      STEP_RUN:    w = '{op: OP_RUN,    cond: COND_ALWAYS,   target: STEP_FETCH};
      STEP_SETUP:  w = '{op: OP_SETUP,  cond: COND_EMPTY,    target: STEP_FETCH};
      STEP_PIXEL:  w = '{op: OP_PIXEL,  cond: COND_LAST,     target: STEP_COMMIT};
      STEP_COMMIT: w = '{op: OP_COMMIT, cond: COND_ALWAYS,   target: STEP_FETCH};
      default:     w = '{op: OP_FETCH,  cond: COND_ALWAYS,   target: STEP_FETCH};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/core/lspe_pixel.sv =====
// Pixel color for one strip position: target color (solid or fade), black, or a run from the middle with shadows.
// Depends on lspe_pkg.
module lspe_pixel
  import lspe_pkg::*;
#(
  parameter int LED_COUNT    = LED_COUNT_DEF,
  parameter int MIDDLE_INDEX = MIDDLE_INDEX_DEF
) (
  input  logic [1:0]                     kind,
  input  logic [$clog2(LED_COUNT)-1:0]   idx,
  input  logic [OFFSET_W-1:0]            run_offset,
  input  rgb_t                           target,
  output rgb_t                           color
);

  localparam int IDX_W = $clog2(LED_COUNT);
  localparam int DW    = (IDX_W > 6) ? IDX_W + 1 : 7;

  logic [DW-1:0] pos;
  logic [DW-1:0] mid;
  logic [DW-1:0] off;
  logic [DW-1:0] span;
  logic [DW-1:0] gap;
  logic          lit;
  rgb_t          run_color;

  function automatic logic [7:0] div_by(input logic [7:0] x, input logic [1:0] sel);
    logic [15:0] prod;
    logic [7:0]  q;
    prod = 16'(x) * 16'd171;
    case (sel)
      2'd0:    q = x;
      2'd1:    q = x >> 1;
      2'd2:    q = {1'b0, prod[15:9]};
      default: q = x >> 2;
    endcase
    return q;
  endfunction

  always_comb begin
    pos  = DW'(idx);
    mid  = DW'(MIDDLE_INDEX);
    off  = DW'(run_offset);
    span = (pos >= mid) ? pos - mid : mid - pos;
    gap  = off - span;
    lit  = (span <= off) && (gap <= DW'(SHADOW_COUNT));
    if (lit) begin
      run_color.red   = div_by(target.red,   gap[1:0]);
      run_color.green = div_by(target.green, gap[1:0]);
      run_color.blue  = div_by(target.blue,  gap[1:0]);
    end else begin
      run_color = '0;
    end
    case (kind)
      KIND_RUN:   color = run_color;
      KIND_BLACK: color = '0;
      default:    color = target;
    endcase
  end

endmodule

// ===== rtl/core/led_strip_pattern_engine.sv =====
// LED strip pattern engine top level: microcoded sequencer, state and output register.
// Depends on lspe_pkg and lspe_pixel.
//
// Input channel in_item/in_valid/in_stall carries commands, fade ticks, run ticks
// and render requests; an item is taken when in_valid is high and in_stall low.
// Output channel out_item/out_valid/out_stall carries pixels; a pixel is taken
// when out_valid is high and out_stall low. Pixels of a frame come in index
// order, last_pixel marks the final one.
// A command, fade tick or run tick takes fetch plus one program step.
// A render takes fetch, a setup step, LED_COUNT pixel steps and a commit step;
// a render that draws nothing takes only fetch and the setup step. The first
// pixel is put into the output register in the first pixel step. The pixel loop
// of the program is the limit: one pixel per cycle while the receiver does not
// stall. While the receiver stalls, the pixel step holds and the output register
// keeps its item; no new input item is taken until the frame is done.
// Reset clears all targets, shown values, the run offset and the output valid,
// and points the step counter at fetch.
module led_strip_pattern_engine
  import lspe_pkg::*;
#(
  parameter int LED_COUNT    = LED_COUNT_DEF,
  parameter int MIDDLE_INDEX = MIDDLE_INDEX_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  localparam int IDX_W = $clog2(LED_COUNT);
  localparam int CW    = 7;

  logic [STEP_W-1:0]   pc;
  logic [STEP_W-1:0]   pc_next;
  ctrl_t               ctrl;
  in_item_t            cmd_item;
  rgb_t                target;
  logic [7:0]          target_level;
  logic [7:0]          active_mode;
  rgb_t                shown;
  logic [7:0]          shown_level;
  logic [OFFSET_W-1:0] run_offset;
  logic [1:0]          kind;
  logic [1:0]          kind_next;
  logic [7:0]          frame_level;
  logic [7:0]          frame_level_next;
  logic [IDX_W-1:0]    pix_idx;
  rgb_t                color;

  logic accept;
  logic emit;
  logic last;
  logic run_live;
  logic differ;
  logic frame_empty;

  assign ctrl     = program_word(pc);
  assign in_stall = (ctrl.op != OP_FETCH);
  assign accept   = in_valid && (ctrl.op == OP_FETCH);
  assign emit     = (ctrl.op == OP_PIXEL) && (!out_valid || !out_stall);
  assign last     = (pix_idx == IDX_W'(LED_COUNT - 1));
  assign run_live = (CW'(run_offset) <= CW'(MIDDLE_INDEX + SHADOW_COUNT));
  assign differ   = (target_level != shown_level) || (target != shown);

  always_comb begin
    frame_empty = 1'b0;
    if (active_mode == MODE_RUN) begin
      kind_next        = run_live ? KIND_RUN : KIND_BLACK;
      frame_level_next = run_live ? target_level : 8'd0;
    end else if (active_mode == MODE_FADE) begin
      kind_next        = KIND_FADE;
      frame_level_next = shown_level;
      frame_empty      = !differ;
    end else begin
      kind_next        = KIND_SOLID;
      frame_level_next = target_level;
      frame_empty      = !differ;
    end
  end

  always_comb begin
    case (ctrl.cond)
      COND_ALWAYS:   pc_next = ctrl.target;
      COND_DISPATCH: pc_next = accept ? ctrl.target + STEP_W'(in_item.action) : pc;
      COND_EMPTY:    pc_next = frame_empty ? ctrl.target : pc + STEP_W'(1);
      COND_LAST:     pc_next = (emit && last) ? pc + STEP_W'(1) : pc;
      default:       pc_next = STEP_FETCH;
    endcase
  end

  lspe_pixel #(
    .LED_COUNT    (LED_COUNT),
    .MIDDLE_INDEX (MIDDLE_INDEX)
  ) u_pixel (
    .kind       (kind),
    .idx        (pix_idx),
    .run_offset (run_offset),
    .target     (target),
    .color      (color)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pc           <= STEP_FETCH;
      cmd_item     <= '0;
      target       <= '0;
      target_level <= '0;
      active_mode  <= '0;
      shown        <= '0;
      shown_level  <= '0;
      run_offset   <= '0;
      kind         <= KIND_SOLID;
      frame_level  <= '0;
      pix_idx      <= '0;
      out_valid    <= 1'b0;
    end else begin
      pc        <= pc_next;
      out_valid <= emit || (out_valid && out_stall);
      if (accept) begin
        cmd_item <= in_item;
      end
      case (ctrl.op)
        OP_CMD: begin
          target.red   <= cmd_item.red;
          target.green <= cmd_item.green;
          target.blue  <= cmd_item.blue;
          target_level <= cmd_item.brightness;
          active_mode  <= cmd_item.mode;
          if (cmd_item.mode == MODE_RUN) begin
            run_offset <= '0;
          end
        end
        OP_FADE: begin
          if (target_level > shown_level) begin
            shown_level <= shown_level + 8'd1;
          end else if (target_level < shown_level) begin
            shown_level <= shown_level - 8'd1;
          end
        end
        OP_RUN: begin
          if (run_live && (run_offset != OFFSET_MAX)) begin
            run_offset <= run_offset + OFFSET_W'(1);
          end
        end
        OP_SETUP: begin
          kind        <= kind_next;
          frame_level <= frame_level_next;
          pix_idx     <= '0;
        end
        OP_PIXEL: begin
          if (emit) begin
            pix_idx <= last ? '0 : pix_idx + IDX_W'(1);
          end
        end
        OP_COMMIT: begin
          if (kind != KIND_BLACK) begin
            shown <= target;
          end
          if ((kind == KIND_SOLID) || (kind == KIND_RUN)) begin
            shown_level <= target_level;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_item.pixel_index      <= 5'(pix_idx);
      out_item.out_red          <= color.red;
      out_item.out_green        <= color.green;
      out_item.out_blue         <= color.blue;
      out_item.frame_brightness <= frame_level;
      out_item.last_pixel       <= last;
    end
  end

endmodule
